// ----- design/evad_pkg.sv -----
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types, constants and codes of the energy voice activity detector.
// ----------------------------------------------------------------------------
`default_nettype none

package evad_pkg;

   // Frame and energy format.
   localparam int MAX_FRAME        = 4096;
   localparam int ENERGY_FRAC_BITS = 8;
   localparam int SAMPLE_W         = 16;
   localparam int TALLY_W          = $clog2(MAX_FRAME + 1);
   localparam int SUM_W            = SAMPLE_W + $clog2(MAX_FRAME);
   localparam int DVD_W            = SUM_W + ENERGY_FRAC_BITS;
   localparam int DCNT_W           = $clog2(DVD_W + 1);
   localparam int ENERGY_W         = 24;
   localparam int TIME_W           = 32;

   // Shared multiplier operand widths.
   localparam int MUL_A_W          = 24;
   localparam int MUL_B_W          = 17;
   localparam int MUL_P_W          = MUL_A_W + MUL_B_W;

   // Frame queue between the front and the back.
   localparam int QDEPTH           = 2;
   localparam int QPTR_W           = $clog2(QDEPTH);

   // Slow adaptation scale (0.1 in Q0.16) and threshold clamp limits.
   localparam logic [MUL_B_W-1:0]  SLOW_SCALE = MUL_B_W'(6554);
   localparam logic [MUL_B_W-1:0]  UNITY_Q16  = MUL_B_W'(65536);
   localparam logic [ENERGY_W-1:0] THR_LO     = ENERGY_W'(50 << ENERGY_FRAC_BITS);
   localparam logic [ENERGY_W-1:0] THR_HI     = ENERGY_W'(500 << ENERGY_FRAC_BITS);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_START_THRESH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HANG_TIME          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_ALPHA        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATION_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_GAIN     = 3'd4;

   // Decision codes.
   localparam logic [1:0] DEC_SILENCE  = 2'd0;
   localparam logic [1:0] DEC_SPEECH   = 2'd1;
   localparam logic [1:0] DEC_HANGOVER = 2'd2;

   // One closed frame as handed from the front to the back.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [TALLY_W-1:0] tally;
      logic [TIME_W-1:0]  time_ms;
   } frame_type;

   // Configuration registers that the sequencer reads. The start threshold
   // acts only at the moment it is written, so it is not kept here.
   typedef struct packed {
      logic [15:0]         hang_time;
      logic [15:0]         noise_alpha;
      logic [15:0]         calibration_length;
      logic [15:0]         threshold_gain;
   } cfg_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIV,
      BK_SAT,
      BK_SLOW,
      BK_SLOW_CHK,
      BK_BLEND_A,
      BK_BLEND_B,
      BK_BLEND_C,
      BK_CAL_CNT,
      BK_THR_MUL,
      BK_THR_SET,
      BK_DECIDE,
      BK_DONE
   } back_state_type;

   // Operand selection of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_SLOW_ALPHA,
      MUL_FLOOR_WEIGHT,
      MUL_ENERGY_WEIGHT,
      MUL_FLOOR_GAIN
   } mul_sel_type;

endpackage

`default_nettype wire

// ----- design/evad_front.sv -----
// ----------------------------------------------------------------------------
// evad_front
// Accepts audio samples, accumulates their magnitudes and pushes each closed
// frame into the frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  signed [15:0]            req_sample,
   input  wire                           req_frame_end,
   input  wire         [31:0]            req_time_ms,
   input  evad_pkg::queue_status_type    q_status,
   output logic                          q_push,
   output evad_pkg::frame_type           q_entry
);
   import evad_pkg::*;

   logic [SUM_W-1:0]    sum_ff, sum_in, sum_add;
   logic [TALLY_W-1:0]  tally_ff, tally_in, tally_add;
   logic [SAMPLE_W-1:0] mag;
   logic                accept;

   // An item is taken whenever the queue can hold a closed frame.
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // Magnitude of the sample; the most negative value maps to 32768.
   assign mag = req_sample[15] ? SAMPLE_W'(~req_sample + 16'sd1) : SAMPLE_W'(req_sample);

   // Accumulate until the frame holds the maximum number of samples.
   always_comb begin
      if (tally_ff < TALLY_W'(MAX_FRAME)) begin
         sum_add   = sum_ff + SUM_W'(mag);
         tally_add = tally_ff + TALLY_W'(1);
      end else begin
         sum_add   = sum_ff;
         tally_add = tally_ff;
      end
   end

   // The last item of a frame closes it and starts a fresh one.
   always_comb begin
      q_push           = accept && req_frame_end;
      q_entry.sum      = sum_add;
      q_entry.tally    = tally_add;
      q_entry.time_ms  = req_time_ms;
      sum_in           = sum_ff;
      tally_in         = tally_ff;
      if (accept) begin
         if (req_frame_end) begin
            sum_in   = '0;
            tally_in = '0;
         end else begin
            sum_in   = sum_add;
            tally_in = tally_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/evad_queue.sv -----
// ----------------------------------------------------------------------------
// evad_queue
// Short queue of closed frames between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_queue (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           push,
   input  evad_pkg::frame_type           push_entry,
   input  wire                           pop,
   output evad_pkg::frame_type           pop_entry,
   output evad_pkg::queue_status_type    status
);
   import evad_pkg::*;

   frame_type           entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = entries_ff[rd_ptr_ff];

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- design/evad_back.sv -----
// ----------------------------------------------------------------------------
// evad_back
// Frame sequencer: serial energy division, noise floor tracking through one
// shared multiplier, threshold derivation and the speech decision.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_back (
   input  wire                           clock,
   input  wire                           reset,
   input  evad_pkg::cfg_type             cfg,
   input  wire                           thr_wr,
   input  wire  [23:0]                   thr_wr_data,
   input  evad_pkg::queue_status_type    q_status,
   input  evad_pkg::frame_type           q_entry,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [1:0]                    rsp_decision,
   output logic [23:0]                   rsp_frame_energy,
   output logic [23:0]                   rsp_current_threshold,
   output logic [23:0]                   rsp_current_noise_floor,
   output logic                          rsp_is_calibrated
);
   import evad_pkg::*;

   back_state_type       state_ff, state_in;
   mul_sel_type          mul_sel;
   logic                 out_load;

   // Divider.
   logic [DVD_W-1:0]     dvd_ff;
   logic [TALLY_W-1:0]   rem_ff;
   logic [TALLY_W-1:0]   divisor_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [TALLY_W:0]     rem_shift;
   logic                 rem_ge;
   logic [ENERGY_W-1:0]  energy_sat;

   // Frame working registers.
   logic [ENERGY_W-1:0]  energy_ff;
   logic [TIME_W-1:0]    time_ff;
   logic [15:0]          alpha_ff;
   logic [1:0]           dec_ff;
   logic [MUL_P_W:0]     acc_ff;

   // Shared multiplier.
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_P_W-1:0]   prod_ff;

   // Detector state.
   logic [ENERGY_W-1:0]  floor_ff;
   logic [ENERGY_W-1:0]  thr_ff;
   logic [15:0]          ccount_ff, ccount_next;
   logic                 cal_ff;
   logic                 streaming_ff;
   logic [TIME_W-1:0]    last_speech_ff;

   // Derived values.
   logic [MUL_P_W:0]     blend_sum;
   logic [MUL_P_W-9:0]   thr_raw;
   logic [ENERGY_W-1:0]  thr_clamped;
   logic [TIME_W-1:0]    since_speech;
   logic                 quiet_frame;

   // Restoring division step and saturation of the quotient.
   assign rem_shift  = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_ge     = (rem_shift >= {1'b0, divisor_ff});
   assign energy_sat = (dvd_ff[DVD_W-1:ENERGY_W] != '0) ? '1 : dvd_ff[ENERGY_W-1:0];

   assign ccount_next  = (ccount_ff == 16'hFFFF) ? ccount_ff : ccount_ff + 16'd1;
   assign blend_sum    = acc_ff + (MUL_P_W+1)'(prod_ff);
   assign thr_raw      = prod_ff[MUL_P_W-1:8];
   assign since_speech = time_ff - last_speech_ff;
   assign quiet_frame  = ({1'b0, energy_ff, 1'b0} < {2'b00, thr_ff});

   // Threshold clamp to the allowed range.
   always_comb begin
      if (thr_raw < (MUL_P_W-8)'(THR_LO)) begin
         thr_clamped = THR_LO;
      end else if (thr_raw > (MUL_P_W-8)'(THR_HI)) begin
         thr_clamped = THR_HI;
      end else begin
         thr_clamped = thr_raw[ENERGY_W-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) state_in = BK_DIV;
         end
         BK_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) state_in = BK_SAT;
         end
         BK_SAT: begin
            if (cal_ff) begin
               state_in = BK_SLOW;
            end else if (floor_ff == '0) begin
               state_in = BK_CAL_CNT;
            end else begin
               state_in = BK_BLEND_A;
            end
         end
         BK_SLOW:     state_in = BK_SLOW_CHK;
         BK_SLOW_CHK: state_in = quiet_frame ? BK_BLEND_A : BK_DECIDE;
         BK_BLEND_A:  state_in = BK_BLEND_B;
         BK_BLEND_B:  state_in = BK_BLEND_C;
         BK_BLEND_C:  state_in = cal_ff ? BK_DECIDE : BK_CAL_CNT;
         BK_CAL_CNT: begin
            state_in = (ccount_next >= cfg.calibration_length) ? BK_THR_MUL : BK_DONE;
         end
         BK_THR_MUL:  state_in = BK_THR_SET;
         BK_THR_SET:  state_in = BK_DONE;
         BK_DECIDE:   state_in = BK_DONE;
         BK_DONE: begin
            if (!rsp_valid || rsp_ready) state_in = BK_IDLE;
         end
         default:     state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      mul_sel  = MUL_FLOOR_WEIGHT;
      case (state_ff)
         BK_IDLE:    q_pop    = !q_status.empty;
         BK_SLOW:    mul_sel  = MUL_SLOW_ALPHA;
         BK_BLEND_A: mul_sel  = MUL_FLOOR_WEIGHT;
         BK_BLEND_B: mul_sel  = MUL_ENERGY_WEIGHT;
         BK_THR_MUL: mul_sel  = MUL_FLOOR_GAIN;
         BK_DONE:    out_load = !rsp_valid || rsp_ready;
         default:    q_pop    = 1'b0;
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      case (mul_sel)
         MUL_SLOW_ALPHA: begin
            mul_a = MUL_A_W'(cfg.noise_alpha);
            mul_b = SLOW_SCALE;
         end
         MUL_FLOOR_WEIGHT: begin
            mul_a = floor_ff;
            mul_b = UNITY_Q16 - MUL_B_W'(alpha_ff);
         end
         MUL_ENERGY_WEIGHT: begin
            mul_a = energy_ff;
            mul_b = MUL_B_W'(alpha_ff);
         end
         MUL_FLOOR_GAIN: begin
            mul_a = floor_ff;
            mul_b = MUL_B_W'(cfg.threshold_gain);
         end
         default: begin
            mul_a = floor_ff;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Product register after the shared multiplier.
   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   // Frame working registers and the divider.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            dvd_ff     <= {q_entry.sum, ENERGY_FRAC_BITS'(0)};
            rem_ff     <= '0;
            divisor_ff <= q_entry.tally;
            dcnt_ff    <= DCNT_W'(DVD_W);
            time_ff    <= q_entry.time_ms;
         end
         BK_DIV: begin
            rem_ff  <= rem_ge ? TALLY_W'(rem_shift - {1'b0, divisor_ff})
                              : rem_shift[TALLY_W-1:0];
            dvd_ff  <= {dvd_ff[DVD_W-2:0], rem_ge};
            dcnt_ff <= dcnt_ff - DCNT_W'(1);
         end
         BK_SAT: begin
            energy_ff <= energy_sat;
            alpha_ff  <= cfg.noise_alpha;
            dec_ff    <= DEC_SILENCE;
         end
         BK_SLOW_CHK: alpha_ff <= prod_ff[31:16];
         BK_BLEND_B:  acc_ff   <= (MUL_P_W+1)'(prod_ff);
         BK_DECIDE: begin
            if (energy_ff > thr_ff) begin
               dec_ff <= DEC_SPEECH;
            end else if (streaming_ff && (since_speech < TIME_W'(cfg.hang_time))) begin
               dec_ff <= DEC_HANGOVER;
            end else begin
               dec_ff <= DEC_SILENCE;
            end
         end
         default:     dec_ff   <= dec_ff;
      endcase
   end

   // Detector state.
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff       <= '0;
         thr_ff         <= '0;
         ccount_ff      <= '0;
         cal_ff         <= 1'b0;
         streaming_ff   <= 1'b0;
         last_speech_ff <= '0;
      end else begin
         if (thr_wr && !cal_ff) begin
            thr_ff <= thr_wr_data;
         end
         case (state_ff)
            BK_SAT: begin
               if (!cal_ff && (floor_ff == '0)) floor_ff <= energy_sat;
            end
            BK_BLEND_C: floor_ff <= blend_sum[ENERGY_W+15:16];
            BK_CAL_CNT: ccount_ff <= ccount_next;
            BK_THR_SET: begin
               thr_ff <= thr_clamped;
               cal_ff <= 1'b1;
            end
            BK_DECIDE: begin
               if (energy_ff > thr_ff) begin
                  last_speech_ff <= time_ff;
                  streaming_ff   <= 1'b1;
               end else if (!(streaming_ff && (since_speech < TIME_W'(cfg.hang_time)))) begin
                  streaming_ff   <= 1'b0;
               end
            end
            default: cal_ff <= cal_ff;
         endcase
      end
   end

   // Result register; the next frame may be divided while it waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_decision            <= dec_ff;
         rsp_frame_energy        <= energy_ff;
         rsp_current_threshold   <= thr_ff;
         rsp_current_noise_floor <= floor_ff;
         rsp_is_calibrated       <= cal_ff;
      end
   end

endmodule

`default_nettype wire

// ----- design/energy_voice_activity_detector.sv -----
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Energy based voice activity detector with noise floor calibration.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one signed audio sample per item; the item with
//   req_frame_end high closes the frame and its req_time_ms is the frame time.
//   The sample front end takes one item per cycle while the frame queue is
//   not full, and sums magnitudes. Each closed frame enters a two-entry
//   frame queue; the frame sequencer then divides the sum serially (one
//   quotient bit per cycle) and updates the noise floor and threshold
//   through one shared multiplier. One rsp item per frame appears after the
//   sequencer has taken the frame from the queue, divided it and run the
//   floor, threshold and decision steps. The sequencer works on one frame
//   at a time, so short frames make the queue fill and req_ready drop.
//   The csr channel writes one register per item and is always ready; it
//   must be written only while no frame is in flight; the block does not
//   enforce this. A held rsp item does not stop the next frame from being
//   divided; the sequencer waits only when it has a second result to hand
//   over. Reset is synchronous: it clears the partial frame, the queue, the
//   noise floor, the calibration count, the threshold and the configuration
//   and control registers to zero; frame data and result registers are not.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_activity_detector (
   input  wire                clock,
   input  wire                reset,
   // Sample input channel.
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  signed [15:0] req_sample,
   input  wire                req_frame_end,
   input  wire         [31:0] req_time_ms,
   // Frame result channel.
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic        [1:0]  rsp_decision,
   output logic        [23:0] rsp_frame_energy,
   output logic        [23:0] rsp_current_threshold,
   output logic        [23:0] rsp_current_noise_floor,
   output logic               rsp_is_calibrated,
   // Register write channel.
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire         [2:0]  csr_index,
   input  wire         [23:0] csr_data
);
   import evad_pkg::*;

   cfg_type           cfg_ff;
   logic              csr_write;
   logic              thr_wr;
   logic              q_push, q_pop;
   frame_type         push_entry, pop_entry;
   queue_status_type  q_status;

   // Register file. The start threshold write goes straight to the
   // sequencer, which loads it while calibration is still running.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign thr_wr    = csr_write && (csr_index == CSR_START_THRESH);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HANG_TIME:          cfg_ff.hang_time          <= csr_data[15:0];
            CSR_NOISE_ALPHA:        cfg_ff.noise_alpha        <= csr_data[15:0];
            CSR_CALIBRATION_LENGTH: cfg_ff.calibration_length <= csr_data[15:0];
            CSR_THRESHOLD_GAIN:     cfg_ff.threshold_gain     <= csr_data[15:0];
            default:                cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   // Sample front end.
   evad_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_frame_end (req_frame_end),
      .req_time_ms   (req_time_ms),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   // Closed frame queue.
   evad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // Frame sequencer.
   evad_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg_ff),
      .thr_wr                  (thr_wr),
      .thr_wr_data             (csr_data),
      .q_status                (q_status),
      .q_entry                 (pop_entry),
      .q_pop                   (q_pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_decision            (rsp_decision),
      .rsp_frame_energy        (rsp_frame_energy),
      .rsp_current_threshold   (rsp_current_threshold),
      .rsp_current_noise_floor (rsp_current_noise_floor),
      .rsp_is_calibrated       (rsp_is_calibrated)
   );

   // A closed frame is never offered to a full queue.
   assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("frame pushed into full queue");

   // Frames before calibration completes are reported as silence.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_calibrated) |-> (rsp_decision == DEC_SILENCE))
      else $error("non-silence decision before calibration");

   // A calibrated threshold stays inside the clamp range.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_calibrated) |->
         (rsp_current_threshold >= THR_LO && rsp_current_threshold <= THR_HI))
      else $error("threshold outside clamp range");

   // Speech is reported only for frames louder than the threshold.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_decision == DEC_SPEECH) |->
         (rsp_frame_energy > rsp_current_threshold))
      else $error("speech decision below threshold");

endmodule

`default_nettype wire
